### rtl/pcmu_pkg.sv
// ----------------------------------------------------------------------------
// pcmu_pkg
// Shared types and constants for the PCM byte stream sample unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmu_pkg;

    localparam int BYTE_W         = 8;
    localparam int SAMPLE_W       = 64;
    localparam int CHAN_W         = 3;
    localparam int CFG_DATA_W     = 5;
    localparam int CFG_INDEX_W    = 2;

    // widest sign-extended sample and the container size that gets it
    localparam logic [4:0] MAX_BIT_WIDTH   = 5'd24;
    localparam logic [3:0] SIGN_EXT_BYTES  = 4'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BYTES_PER_SAMPLE = 2'd0,
        REG_CHANNEL_COUNT    = 2'd1,
        REG_BIG_ENDIAN_ORDER = 2'd2,
        REG_SAMPLE_BIT_WIDTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [3:0] bytes_per_sample;
        logic [3:0] channel_count;
        logic       big_endian_order;
        logic [4:0] sample_bit_width;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_word;
        logic [CHAN_W-1:0]   channel_index;
        logic                frame_last;
    } result_t;

endpackage : pcmu_pkg

`default_nettype wire

### rtl/pcmu_assemble.sv
// ----------------------------------------------------------------------------
// pcmu_assemble
// Byte gathering state, byte order assembly, 3-byte sign extension and
// channel tracking. One byte per accepted transaction, one result per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmu_assemble
    import pcmu_pkg::*;
#(
    parameter int MAX_SAMPLE_BYTES = 8,
    parameter int MAX_CHANNELS     = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic                   result_valid,
    output result_t                result
);

    localparam int         ACC_LANES   = MAX_SAMPLE_BYTES - 1;
    localparam int         ACC_W       = ACC_LANES * BYTE_W;
    localparam logic [3:0] MAX_BYTES_C = 4'(MAX_SAMPLE_BYTES);
    localparam logic [3:0] MAX_CHANS_C = 4'(MAX_CHANNELS);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2:0]        byte_count_reg, byte_count_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;

    logic [3:0]          n_bytes, n_m1, n_chans;
    logic [4:0]          width, width_m1;
    logic                done, last;
    logic [BYTE_W-1:0]   byte_lane [MAX_SAMPLE_BYTES];
    logic [SAMPLE_W-1:0] word_le, word_be, word_raw, word_out;
    logic                sign_bit;

    always_comb
    begin
        // effective settings, saturated into range
        if (cfg.bytes_per_sample == 4'd0)
            n_bytes = 4'd1;
        else if (cfg.bytes_per_sample > MAX_BYTES_C)
            n_bytes = MAX_BYTES_C;
        else
            n_bytes = cfg.bytes_per_sample;

        if (cfg.channel_count == 4'd0)
            n_chans = 4'd1;
        else if (cfg.channel_count > MAX_CHANS_C)
            n_chans = MAX_CHANS_C;
        else
            n_chans = cfg.channel_count;

        if (cfg.sample_bit_width == 5'd0)
            width = 5'd1;
        else if (cfg.sample_bit_width > MAX_BIT_WIDTH)
            width = MAX_BIT_WIDTH;
        else
            width = cfg.sample_bit_width;

        n_m1     = n_bytes - 4'd1;
        width_m1 = width - 5'd1;
        done     = ({1'b0, byte_count_reg} >= n_m1);

        // bytes in arrival order; a size change mid-sample drops extras
        for (int k = 0; k < MAX_SAMPLE_BYTES; k++)
            byte_lane[k] = '0;
        for (int k = 0; k < ACC_LANES; k++)
            if (4'(k) < n_m1)
                byte_lane[k] = acc_reg[k*BYTE_W +: BYTE_W];
        for (int k = 0; k < MAX_SAMPLE_BYTES; k++)
            if (4'(k) == n_m1)
                byte_lane[k] = data_byte;

        word_le = '0;
        for (int k = 0; k < MAX_SAMPLE_BYTES; k++)
            word_le[k*BYTE_W +: BYTE_W] = byte_lane[k];

        // big endian: arrival byte k lands in word byte n-1-k
        word_be = '0;
        for (int j = 0; j < MAX_SAMPLE_BYTES; j++)
            for (int k = 0; k < MAX_SAMPLE_BYTES; k++)
                if (5'(j) + 5'(k) == {1'b0, n_m1})
                    word_be[j*BYTE_W +: BYTE_W] = byte_lane[k];

        word_raw = cfg.big_endian_order ? word_be : word_le;

        sign_bit = word_raw[width_m1];
        if (n_bytes == SIGN_EXT_BYTES)
        begin
            for (int i = 0; i < SAMPLE_W; i++)
                word_out[i] = (6'(i) < {1'b0, width}) ? word_raw[i] : sign_bit;
        end
        else
        begin
            word_out = word_raw;
        end

        last = ({1'b0, chan_reg} + 4'd1 >= n_chans);

        acc_next        = acc_reg;
        byte_count_next = byte_count_reg;
        chan_next       = chan_reg;
        if (accept)
        begin
            if (done)
            begin
                acc_next        = '0;
                byte_count_next = 3'd0;
                chan_next       = last ? '0 : chan_reg + 3'd1;
            end
            else
            begin
                for (int k = 0; k < ACC_LANES; k++)
                    if (4'({1'b0, byte_count_reg}) == 4'(k))
                        acc_next[k*BYTE_W +: BYTE_W] =
                            acc_reg[k*BYTE_W +: BYTE_W] | data_byte;
                byte_count_next = byte_count_reg + 3'd1;
            end
        end

        result_valid         = accept && done;
        result.sample_word   = word_out;
        result.channel_index = chan_reg;
        result.frame_last    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            byte_count_reg <= 3'd0;
            chan_reg       <= '0;
        end
        else
        begin
            acc_reg        <= acc_next;
            byte_count_reg <= byte_count_next;
            chan_reg       <= chan_next;
        end
    end

endmodule : pcmu_assemble

`default_nettype wire

### rtl/pcmu_out_buf.sv
// ----------------------------------------------------------------------------
// pcmu_out_buf
// Output register with a skid stage; upstream ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmu_out_buf
    import pcmu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         ready,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_ready)
        begin
            // output slot frees up; skid drains first (push is held off then)
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                    out_data_next = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : pcmu_out_buf

`default_nettype wire

### rtl/pcm_byte_stream_sample_unpacker_core.sv
// ----------------------------------------------------------------------------
// pcm_byte_stream_sample_unpacker_core
// Gathers PCM bytes into samples in the configured byte order.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, every cycle, while s_tready is high. The byte
// that completes a sample is assembled, sign-extended for 3-byte containers
// and registered in the same cycle, into the output register or, while that
// holds an untaken sample, into the skid stage. s_tready falls only when the
// output register and the skid stage both hold a sample that the sink has
// not yet taken. There is no start-up pass after reset. Configuration writes
// take effect on the next byte and must only be made while no sample is
// part-gathered or waiting.
`default_nettype none

module pcm_byte_stream_sample_unpacker_core
    import pcmu_pkg::*;
#(
    parameter int MAX_SAMPLE_BYTES = 8,
    parameter int MAX_CHANNELS     = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wen,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] data_byte

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [63:0]                 m_tdata,   // [63:0] sample_word
    output logic [2:0]                  m_tuser,   // [2:0] channel_index
    output logic                        m_tlast    // frame_last
);

    cfg_t    cfg_reg, cfg_next;
    logic    accept;
    logic    result_valid;
    result_t result;
    result_t out_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_BYTES_PER_SAMPLE: cfg_next.bytes_per_sample = cfg_data[3:0];
                REG_CHANNEL_COUNT:    cfg_next.channel_count    = cfg_data[3:0];
                REG_BIG_ENDIAN_ORDER: cfg_next.big_endian_order = cfg_data[0];
                REG_SAMPLE_BIT_WIDTH: cfg_next.sample_bit_width = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_sample <= 4'd2;
            cfg_reg.channel_count    <= 4'd2;
            cfg_reg.big_endian_order <= 1'b0;
            cfg_reg.sample_bit_width <= MAX_BIT_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    pcmu_assemble #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES),
        .MAX_CHANNELS     (MAX_CHANNELS)
    ) u_assemble (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .data_byte    (s_tdata),
        .result_valid (result_valid),
        .result       (result)
    );

    pcmu_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = out_data.sample_word;
    assign m_tuser = out_data.channel_index;
    assign m_tlast = out_data.frame_last;

endmodule : pcm_byte_stream_sample_unpacker_core

`default_nettype wire
